// File: rtl/ipssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipssr_pkg
// Shared types for the indexed point set: commands, status codes and the
// controller states.
// ----------------------------------------------------------------------------
package ipssr_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned IdxW = 8;
  localparam int unsigned UsedW = 9;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_LOOK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DEL,
    FSM_DONE
  } fsm_e;

endpackage

// File: rtl/indexed_point_set_swap_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_point_set_swap_remove
// Add and lookup scan the held entries in order and stop early on a hit;
//   delete and no-op skip the scan.
// One command at a time, set by the serial key scan through the single read
//   port of the table memory; a new command waits for the last one's result.
// Reset: clears the entry count and control state; the table memory is not
//   cleared and only entries below the count are ever used.
// ----------------------------------------------------------------------------
module indexed_point_set_swap_remove #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ipssr_pkg::cmd_e      command_i,
  input  logic [63:0]          key_x_i,
  input  logic [63:0]          key_y_i,
  input  logic [7:0]           entry_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ipssr_pkg::status_e   status_o,
  output logic                 found_o,
  output logic [7:0]           result_index_o,
  output logic [8:0]           entries_used_o
);
  import ipssr_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > IdxW) ? CW : IdxW;
  localparam int unsigned DW = 2 * KeyW;

  logic [DW-1:0] tbl_mem [TABLE_DEPTH];

  fsm_e            state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   scan_ptr_q, scan_ptr_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]   cmp_idx_q, cmp_idx_d;
  cmd_e            cmd_q, cmd_d;
  logic [KeyW-1:0] kx_q, kx_d, ky_q, ky_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [DW-1:0]   rd_data_q;
  status_e         res_status_q, res_status_d;
  logic            res_found_q, res_found_d;
  logic [IdxW-1:0] res_index_q, res_index_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  logic            out_found_q, out_found_d;
  logic [IdxW-1:0] out_index_q, out_index_d;
  logic [UsedW-1:0] out_used_q, out_used_d;

  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_ra, mem_wa;
  logic [DW-1:0]   mem_wd;

  logic            accept;
  logic            issue;
  logic            scan_hit, scan_miss;
  logic [CW-1:0]   last_c;
  logic            del_range, del_is_last;
  logic            out_free;

  assign accept      = in_valid_i && (state_q == FSM_IDLE);
  assign issue       = scan_ptr_q < cnt_q;
  assign scan_hit    = cmp_vld_q && (rd_data_q == {kx_q, ky_q});
  assign scan_miss   = !issue && !scan_hit;
  assign last_c      = cnt_q - 1'b1;
  assign del_range   = CMPW'(idx_q) >= CMPW'(cnt_q);
  assign del_is_last = CMPW'(idx_q) == CMPW'(last_c);
  assign out_free    = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_ADD:  state_d = FSM_SCAN;
            CMD_LOOK: state_d = FSM_SCAN;
            CMD_DEL:  state_d = FSM_DEL;
            default:  state_d = FSM_DONE;
          endcase
        end
      end
      FSM_SCAN: begin
        if (scan_hit || scan_miss) state_d = FSM_DONE;
      end
      FSM_DEL:  state_d = FSM_DONE;
      FSM_DONE: begin
        if (out_free) state_d = FSM_IDLE;
      end
      default:  state_d = FSM_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall_o   = (state_q != FSM_IDLE);
    mem_re       = 1'b0;
    mem_ra       = last_c[AW-1:0];
    mem_we       = 1'b0;
    mem_wa       = cnt_q[AW-1:0];
    mem_wd       = {kx_q, ky_q};
    cnt_d        = cnt_q;
    scan_ptr_d   = scan_ptr_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = scan_ptr_q[AW-1:0];
    cmd_d        = cmd_q;
    kx_d         = kx_q;
    ky_d         = ky_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_index_d  = res_index_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_index_d  = out_index_q;
    out_used_d   = out_used_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          cmd_d        = command_i;
          kx_d         = key_x_i;
          ky_d         = key_y_i;
          idx_d        = entry_index_i;
          scan_ptr_d   = '0;
          mem_re       = 1'b1;
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          res_index_d  = '0;
        end
      end
      FSM_SCAN: begin
        mem_re     = issue;
        mem_ra     = scan_ptr_q[AW-1:0];
        cmp_vld_d  = issue;
        if (issue) scan_ptr_d = scan_ptr_q + 1'b1;
        if (scan_hit) begin
          res_index_d = IdxW'(cmp_idx_q);
          if (cmd_q == CMD_ADD) begin
            res_status_d = ST_DUP;
          end else begin
            res_found_d = 1'b1;
          end
        end else if (scan_miss && (cmd_q == CMD_ADD)) begin
          if (cnt_q == CW'(TABLE_DEPTH)) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we      = 1'b1;
            res_index_d = IdxW'(cnt_q);
            cnt_d       = cnt_q + 1'b1;
          end
        end
      end
      FSM_DEL: begin
        if (del_range) begin
          res_status_d = ST_RANGE;
        end else begin
          // swap the last entry into the hole
          mem_we      = !del_is_last;
          mem_wa      = AW'(idx_q);
          mem_wd      = rd_data_q;
          cnt_d       = last_c;
          res_index_d = idx_q;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_index_d  = res_index_q;
          out_used_d   = UsedW'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tbl_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= tbl_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      scan_ptr_q  <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_ptr_q  <= scan_ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    cmd_q        <= cmd_d;
    kx_q         <= kx_d;
    ky_q         <= ky_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_index_q  <= res_index_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_index_q  <= out_index_d;
    out_used_q   <= out_used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_o        = out_found_q;
  assign result_index_o = out_index_q;
  assign entries_used_o = out_used_q;

endmodule

// File: rtl/ipssr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipssr_checker
// Port-level checks on the indexed point set, bound to the top level.
// ----------------------------------------------------------------------------
module ipssr_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  ipssr_pkg::status_e   status_o,
  input  logic                 found_o,
  input  logic [7:0]           result_index_o,
  input  logic [8:0]           entries_used_o
);
  import ipssr_pkg::*;

  // one command in flight: a beat in blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a command is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(found_o) &&
       $stable(result_index_o) && $stable(entries_used_o)))
    else $error("stalled result beat changed");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == ST_OK))
    else $error("lookup hit with error status");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_RANGE)) |->
      (result_index_o == 8'd0 && !found_o))
    else $error("rejected command returned an index");

endmodule

bind indexed_point_set_swap_remove ipssr_checker u_ipssr_checker (.*);
